FILE: sv/bsc_pkg.sv
// bsc_pkg: types, register codes and byte-level cipher primitives
// shared by the byte cipher modules; depends on nothing
package bsc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NIB_W     = 4;

    typedef enum logic [1:0] {
        MODE_ECB_ENC = 2'd0,
        MODE_ECB_DEC = 2'd1,
        MODE_CBC_ENC = 2'd2,
        MODE_CBC_DEC = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY  = 2'd0,
        REG_IV   = 2'd1,
        REG_MODE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] iv;
        t_mode             mode;
    } t_cfg;

    typedef struct packed {
        logic              upd;
        logic [BYTE_W-1:0] value;
    } t_chain_upd;

    // nibble s-box: 7x + 7 mod 16
    function automatic logic [NIB_W-1:0] sub_nib(input logic [NIB_W-1:0] x);
        return NIB_W'(x * 4'd7 + 4'd7);
    endfunction

    // inverse: 7(y - 7) = 7y + 15 mod 16, since 7 * 7 = 1 mod 16
    function automatic logic [NIB_W-1:0] inv_sub_nib(input logic [NIB_W-1:0] y);
        return NIB_W'(y * 4'd7 + 4'd15);
    endfunction

    function automatic logic [BYTE_W-1:0] sub_byte(input logic [BYTE_W-1:0] b);
        return {sub_nib(b[7:4]), sub_nib(b[3:0])};
    endfunction

    function automatic logic [BYTE_W-1:0] inv_sub_byte(input logic [BYTE_W-1:0] b);
        return {inv_sub_nib(b[7:4]), inv_sub_nib(b[3:0])};
    endfunction

    function automatic logic [BYTE_W-1:0] rotl2(input logic [BYTE_W-1:0] b);
        return {b[5:0], b[7:6]};
    endfunction

    function automatic logic [BYTE_W-1:0] rotl6(input logic [BYTE_W-1:0] b);
        return {b[1:0], b[7:2]};
    endfunction

    // round key 0 is the top byte of the key
    function automatic logic [BYTE_W-1:0] round_key(input logic [KEY_W-1:0] key,
                                                    input logic [1:0]       rnd);
        logic [BYTE_W-1:0] rk;
        case (rnd)
            2'd0:    rk = key[31:24];
            2'd1:    rk = key[23:16];
            2'd2:    rk = key[15:8];
            default: rk = key[7:0];
        endcase
        return rk;
    endfunction

endpackage

FILE: sv/byte_spn_cipher_ecb_cbc.sv
// byte_spn_cipher_ecb_cbc: byte-wide 4-round spn cipher, ecb and cbc modes
// depends on bsc_pkg, bsc_cfg_regs, bsc_datapath
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  input    | i_in_valid / o_in_ready   | i_data_byte, i_last_byte
//  output   | o_out_valid / i_out_ready | o_result_byte
//  config   | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// one word per cycle sustained while the output is not stalled; a word goes
// from input accept to output valid through input register, cipher logic, result register.
// the cbc chain byte is updated as a word leaves the input register, so the
// next word already sees it on the following cycle.
// synchronous active-low reset clears both stages, config, chain and
// puts the next word at a message start. an output stall holds the result
// register and backs up into the input register, then drops o_in_ready.
module byte_spn_cipher_ecb_cbc
    import bsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_result_byte
);

    t_cfg              cfg;
    logic [BYTE_W-1:0] dp_result;
    t_chain_upd        dp_chain_upd;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [BYTE_W-1:0] r_chain;
    logic              r_msg_start;

    logic              n_in_valid;
    logic              n_out_valid;
    logic [BYTE_W-1:0] n_chain;
    logic              n_msg_start;

    logic              in_acc;
    logic              advance;

    bsc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bsc_datapath u_dp (
        .i_cfg       (cfg),
        .i_data      (r_in_data),
        .i_chain     (r_chain),
        .i_msg_start (r_msg_start),
        .o_result    (dp_result),
        .o_chain_upd (dp_chain_upd)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid  = in_acc ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : ((r_out_valid && i_out_ready) ? 1'b0 : r_out_valid);
        n_chain     = (advance && dp_chain_upd.upd) ? dp_chain_upd.value : r_chain;
        n_msg_start = advance ? r_in_last : r_msg_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
            r_msg_start <= 1'b1;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
            r_msg_start <= n_msg_start;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (advance) begin
            r_out_byte <= dp_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out_byte;

    // a word that moves on always lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register empty after a word moved on");

    // message boundary follows the flag of the word that moved on
    a_msg_start_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_msg_start == $past(r_in_last)))
        else $error("message start flag out of step with last flag");

    // cbc encrypt chains on its own ciphertext
    a_cbc_enc_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (cfg.mode == MODE_CBC_ENC)) |=> (r_chain == r_out_byte))
        else $error("cbc encrypt chain byte differs from ciphertext");

    // ecb leaves the chain byte alone
    a_ecb_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (cfg.mode == MODE_ECB_ENC || cfg.mode == MODE_ECB_DEC))
        |=> $stable(r_chain))
        else $error("chain byte changed in ecb mode");

endmodule

FILE: sv/bsc_cfg_regs.sv
// bsc_cfg_regs: key, iv and mode registers behind the plain write port
// depends on bsc_pkg
module bsc_cfg_regs
    import bsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KEY:  n_cfg.key  = i_cfg_data;
                REG_IV:   n_cfg.iv   = i_cfg_data[BYTE_W-1:0];
                REG_MODE: n_cfg.mode = t_mode'(i_cfg_data[1:0]);
                default:  n_cfg = r_cfg; // unused index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key  <= '0;
            r_cfg.iv   <= '0;
            r_cfg.mode <= MODE_ECB_ENC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/bsc_datapath.sv
// bsc_datapath: four-round encrypt and decrypt of one word plus cbc chaining
// pure combinational; depends on bsc_pkg
module bsc_datapath
    import bsc_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic [BYTE_W-1:0] i_data,
    input  logic [BYTE_W-1:0] i_chain,
    input  logic              i_msg_start,
    output logic [BYTE_W-1:0] o_result,
    output t_chain_upd        o_chain_upd
);

    function automatic logic [BYTE_W-1:0] encrypt(input logic [BYTE_W-1:0] v,
                                                  input logic [KEY_W-1:0]  key);
        logic [BYTE_W-1:0] t;
        t = v ^ round_key(key, 2'd0);
        t = rotl2(sub_byte(t)) ^ round_key(key, 2'd1);
        t = rotl2(sub_byte(t)) ^ round_key(key, 2'd2);
        t = sub_byte(t) ^ round_key(key, 2'd3);
        return t;
    endfunction

    function automatic logic [BYTE_W-1:0] decrypt(input logic [BYTE_W-1:0] v,
                                                  input logic [KEY_W-1:0]  key);
        logic [BYTE_W-1:0] t;
        t = inv_sub_byte(v ^ round_key(key, 2'd3)) ^ round_key(key, 2'd2);
        t = inv_sub_byte(rotl6(t)) ^ round_key(key, 2'd1);
        t = inv_sub_byte(rotl6(t)) ^ round_key(key, 2'd0);
        return t;
    endfunction

    logic [BYTE_W-1:0] prev;
    logic [BYTE_W-1:0] enc_in;
    logic [BYTE_W-1:0] enc_out;
    logic [BYTE_W-1:0] dec_out;

    always_comb begin
        prev    = i_msg_start ? i_cfg.iv : i_chain;
        enc_in  = (i_cfg.mode == MODE_CBC_ENC) ? (i_data ^ prev) : i_data;
        enc_out = encrypt(enc_in, i_cfg.key);
        dec_out = decrypt(i_data, i_cfg.key);

        o_chain_upd.upd   = 1'b0;
        o_chain_upd.value = enc_out;
        case (i_cfg.mode)
            MODE_ECB_ENC: o_result = enc_out;
            MODE_ECB_DEC: o_result = dec_out;
            MODE_CBC_ENC: begin
                o_result        = enc_out;
                o_chain_upd.upd = 1'b1;
            end
            MODE_CBC_DEC: begin
                o_result          = dec_out ^ prev;
                o_chain_upd.upd   = 1'b1;
                o_chain_upd.value = i_data;
            end
            default: o_result = enc_out;
        endcase
    end

endmodule

FILE: sim/byte_spn_cipher_ecb_cbc_tb.sv
// byte_spn_cipher_ecb_cbc_tb: self-checking bench for the byte spn cipher in all four modes
// depends on bsc_pkg and byte_spn_cipher_ecb_cbc
`timescale 1ns / 100ps

module byte_spn_cipher_ecb_cbc_tb;
    import bsc_pkg::*;

    // index with no register behind it, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int WORDS_WANTED = 1900;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_word_in;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [KEY_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 i_last_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BYTE_W-1:0]    o_result_byte;

    // expected cipher state and register copies
    logic [KEY_W-1:0]  model_key  = '0;
    logic [BYTE_W-1:0] model_iv   = '0;
    t_mode             model_mode = MODE_ECB_ENC;
    logic [BYTE_W-1:0] chain_val  = '0;
    logic              msg_start  = 1'b1;

    t_word_in          pend_q[$];
    logic [BYTE_W-1:0] result_q[$];

    bit        in_fire    = 1'b0;
    bit        tx_steady  = 1'b1;
    bit        rx_open    = 1'b1;
    int        burst_left = 0;
    int        gap_left   = 0;
    logic [15:0] stall_pat = '0;
    int        pat_left   = 0;
    int        err_cnt    = 0;
    int        words_queued = 0;
    int        words_checked = 0;
    int        cfg_phases = 0;
    int        mode_words[4] = '{0, 0, 0, 0};

    byte_spn_cipher_ecb_cbc DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_byte (o_result_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // nibble map 7x + 7, truncated to four bits
    function automatic logic [BYTE_W-1:0] subst(input logic [BYTE_W-1:0] b);
        logic [3:0] hi, lo;
        hi = b[7:4] * 4'd7 + 4'd7;
        lo = b[3:0] * 4'd7 + 4'd7;
        return {hi, lo};
    endfunction

    // the map has order four, so three passes undo one
    function automatic logic [BYTE_W-1:0] unsubst(input logic [BYTE_W-1:0] b);
        return subst(subst(subst(b)));
    endfunction

    function automatic logic [BYTE_W-1:0] encipher(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = b ^ model_key[31:24];
        v = subst(v);
        v = {v[5:0], v[7:6]} ^ model_key[23:16];
        v = subst(v);
        v = {v[5:0], v[7:6]} ^ model_key[15:8];
        return subst(v) ^ model_key[7:0];
    endfunction

    function automatic logic [BYTE_W-1:0] decipher(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = unsubst(b ^ model_key[7:0]) ^ model_key[15:8];
        v = unsubst({v[1:0], v[7:2]}) ^ model_key[23:16];
        v = unsubst({v[1:0], v[7:2]}) ^ model_key[31:24];
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] cipher_step(input logic [BYTE_W-1:0] din,
                                                      input logic              last);
        logic [BYTE_W-1:0] prev, res;
        prev = msg_start ? model_iv : chain_val;
        case (model_mode)
            MODE_ECB_ENC: res = encipher(din);
            MODE_ECB_DEC: res = decipher(din);
            MODE_CBC_ENC: begin
                res = encipher(din ^ prev);
                chain_val = res;
            end
            default: begin
                res = decipher(din) ^ prev;
                chain_val = din;
            end
        endcase
        mode_words[model_mode]++;
        msg_start = last;
        return res;
    endfunction

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        logic [BYTE_W-1:0] want;
        if (!i_rst_n) begin
            in_fire = 1'b0;
        end else begin
            in_fire = i_in_valid && o_in_ready;
            if (in_fire)
                result_q.push_back(cipher_step(i_data_byte, i_last_byte));
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("result_byte: expected nothing, actual %02h", o_result_byte);
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    words_checked++;
                    if (o_result_byte !== want) begin
                        $error("result_byte: expected %02h, actual %02h", want, o_result_byte);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // sender: bursts of words with random gaps, or back to back when steady
    always @(negedge i_clk) begin
        t_word_in w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                w = pend_q.pop_front();
                i_in_valid  <= 1'b1;
                i_data_byte <= w.data;
                i_last_byte <= w.last;
                if (burst_left > 0) begin
                    burst_left--;
                end else if (!tx_steady) begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: stalls follow a random 16-bit pattern unless left open
    always @(negedge i_clk) begin
        if (rx_open) begin
            i_out_ready <= 1'b1;
        end else begin
            if (pat_left == 0) begin
                stall_pat = 16'($urandom());
                pat_left  = 16;
            end
            i_out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_left--;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_KEY:  model_key  = data;
            REG_IV:   model_iv   = data[BYTE_W-1:0];
            REG_MODE: model_mode = t_mode'(data[1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_word(input logic [BYTE_W-1:0] data, input logic last);
        t_word_in w;
        w.data = data;
        w.last = last;
        pend_q.push_back(w);
        words_queued++;
    endtask

    // block is idle once every queued word has come back out
    task automatic wait_idle();
        while (words_checked != words_queued)
            @(negedge i_clk);
        cfg_phases++;
    endtask

    function automatic logic [KEY_W-1:0] pick_cfg();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    task automatic pick_pacing();
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_open   = ($urandom_range(0, 3) == 0);
        burst_left = 0;
    endtask

    initial begin
        int n, len;
        bit noisy, open_end, first;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_out_ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers as reset left them
        pick_pacing();
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        wait_idle();

        // cbc encrypt with all-ones key and iv, last message left open
        pick_pacing();
        write_reg(REG_KEY, 32'hFFFF_FFFF);
        write_reg(REG_IV, 32'h0000_00FF);
        write_reg(REG_MODE, 32'(MODE_CBC_ENC));
        push_word(8'h00, 1'b0);
        push_word(8'hA5, 1'b0);
        push_word(8'hFF, 1'b1);
        push_word(8'h5A, 1'b0);
        wait_idle();

        // ecb in the middle of a cbc message leaves the chain alone
        write_reg(REG_MODE, 32'(MODE_ECB_ENC));
        push_word(8'h3C, 1'b0);
        wait_idle();

        // back to cbc mid-message; new iv (high bits set) waits for next message
        write_reg(REG_MODE, 32'(MODE_CBC_DEC));
        write_reg(REG_IV, 32'hFFFF_FF5A);
        push_word(8'hC3, 1'b0);
        push_word(8'h7E, 1'b1);
        push_word(8'h81, 1'b0);
        wait_idle();

        // write to the unused index, mode with junk high bits
        pick_pacing();
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        write_reg(REG_KEY, 32'h0F1E_2D3C);
        write_reg(REG_MODE, 32'hFFFF_FFF1);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h55, 1'b1);
        wait_idle();

        // a single-word message and key bits at both ends
        write_reg(REG_KEY, 32'h8000_0001);
        write_reg(REG_IV, 32'h0000_0000);
        write_reg(REG_MODE, 32'(MODE_CBC_ENC));
        push_word(8'h01, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'hFE, 1'b1);
        push_word(8'h7F, 1'b1);
        wait_idle();

        write_reg(REG_KEY, 32'h0000_0000);
        write_reg(REG_MODE, 32'(MODE_CBC_DEC));
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);
        wait_idle();

        // random settings, mostly well-formed messages with random content
        first = 1'b1;
        while (words_queued < WORDS_WANTED) begin
            pick_pacing();
            if (first || $urandom_range(0, 2) == 0)
                write_reg(REG_KEY, pick_cfg());
            if (first || $urandom_range(0, 2) == 0)
                write_reg(REG_IV, pick_cfg());
            if (first || $urandom_range(0, 1) == 0)
                write_reg(REG_MODE, $urandom());
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_NONE, $urandom());
            first = 1'b0;
            n = $urandom_range(16, 80);
            while (n > 0) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 10);
                noisy    = ($urandom_range(0, 9) == 0);
                open_end = ($urandom_range(0, 11) == 0);
                for (int k = 0; k < len; k++)
                    push_word(8'($urandom_range(0, 255)),
                              noisy ? 1'($urandom_range(0, 1)) : (k == len - 1 && !open_end));
                n -= len;
            end
            wait_idle();
        end

        // let any stray word show up before the final check
        repeat (10) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("result_byte: %0d expected words never arrived", result_q.size());
            err_cnt++;
        end
        $display("checked %0d words over %0d register settings", words_checked, cfg_phases);
        $display("per mode: ecb enc %0d, ecb dec %0d, cbc enc %0d, cbc dec %0d",
                 mode_words[0], mode_words[1], mode_words[2], mode_words[3]);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
